@@ rtl/ihm_pkg.sv @@
// Shared constants, types and hash helpers of the inode pair hash map.
`default_nettype none

package ihm_pkg;

  // Table geometry
  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned LIVE_W   = IDX_W + 1;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned HALF_W   = KEY_W / 2;

  // Mixer multipliers
  localparam logic [KEY_W-1:0] MIX_MUL_A = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [KEY_W-1:0] MIX_MUL_B = 64'hBF58_476D_1CE4_E5B9;

  typedef enum logic [1:0] {
    MODE_LOOKUP   = 2'd0,
    MODE_REMEMBER = 2'd1,
    MODE_FORGET   = 2'd2,
    MODE_UNUSED   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_NOT_FOUND = 3'd0,
    ST_FOUND     = 3'd1,
    ST_INSERTED  = 3'd2,
    ST_FULL      = 3'd3,
    ST_REMOVED   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_LIVE  = 2'd1,
    MARK_TOMB  = 2'd2
  } mark_e;

  // Hash sequence: three partial products per 64-bit multiply
  typedef enum logic [3:0] {
    HS_A_LL  = 4'd0,
    HS_A_LH  = 4'd1,
    HS_A_HL  = 4'd2,
    HS_A_ACC = 4'd3,
    HS_MIX1  = 4'd4,
    HS_B_LL  = 4'd5,
    HS_B_LH  = 4'd6,
    HS_B_HL  = 4'd7,
    HS_B_ACC = 4'd8,
    HS_HOME  = 4'd9
  } hash_step_e;

  // One table row
  typedef struct packed {
    mark_e                mark;
    logic [KEY_W-1:0]     dev;
    logic [KEY_W-1:0]     ino;
    logic [HANDLE_W-1:0]  handle;
  } slot_t;

  // Controller to datapath
  typedef struct packed {
    logic        load_key;
    logic        hash_en;
    hash_step_e  hash_step;
    logic        rd_en;
    logic        track_free;
    logic        advance;
    logic        wr_en;
    mark_e       wr_mark;
    logic        wr_at_free;
    logic        res_load;
    status_e     res_status;
    logic        res_use_handle;
    logic        out_load;
  } ihm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic slot_empty;
    logic slot_match;
    logic free_avail;
    logic probe_last;
    logic clr_last;
    logic table_full;
  } ihm_sts_t;

  function automatic logic [KEY_W-1:0] mix30(input logic [KEY_W-1:0] h);
    return h ^ (h >> 30);
  endfunction

  function automatic logic [IDX_W-1:0] fold27(input logic [KEY_W-1:0] h);
    logic [KEY_W-1:0] t;
    t = h ^ (h >> 27);
    return t[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/ihm_req_if.sv @@
// Request channel: mode and (device, inode) key with handle.
`default_nettype none

interface ihm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [63:0] device_id;
  logic [63:0] inode_id;
  logic [31:0] value_handle;

  modport source (output valid, mode, device_id, inode_id, value_handle, input ready);
  modport sink   (input valid, mode, device_id, inode_id, value_handle, output ready);
endinterface

`default_nettype wire

@@ rtl/ihm_rsp_if.sv @@
// Response channel: status and found handle.
`default_nettype none

interface ihm_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] found_handle;

  modport source (output valid, status, found_handle, input ready);
  modport sink   (input valid, status, found_handle, output ready);
endinterface

`default_nettype wire

@@ rtl/inode_pair_hash_map.sv @@
// Top level of the inode pair hash map: controller plus datapath.
//
// Usage: requests arrive on req_i (valid/ready), one result leaves on rsp_o
// for every request, in order. A transaction on req_i carries a mode
// (lookup, remember, forget), a 64-bit device and inode key and a 32-bit
// handle. The rsp_o transaction carries a status and the found handle.
// One request is worked on at a time. A request is accepted, then hashed
// on the shared 32x32 multiplier (two 64-bit multiplies of three partial
// products each); each probed slot then takes a registered read of the
// single-port slot memory and a compare, and the result moves to the
// output register. An unused mode answers without touching the table. The
// next request is taken the cycle after the previous result moves to the
// output register. After reset the block sweeps all 1024 slots to empty,
// one per cycle, and holds req_i ready low until the sweep ends.
// The output register frees the controller: the next request is taken while
// a result waits. If rsp_o stalls, the following result is held until the
// output register empties, and no further request is taken meanwhile.
`default_nettype none

module inode_pair_hash_map import ihm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ihm_req_if.sink   req_i,
  ihm_rsp_if.source rsp_o
);

  ihm_cmd_t cmd;
  ihm_sts_t sts;
  logic     in_ready;
  logic     out_valid;

  // Control
  ihm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (in_ready),
    .mode_i      (req_i.mode),
    .out_valid_o (out_valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath
  ihm_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .device_id_i    (req_i.device_id),
    .inode_id_i     (req_i.inode_id),
    .value_handle_i (req_i.value_handle),
    .status_o       (rsp_o.status),
    .found_handle_o (rsp_o.found_handle)
  );

  assign req_i.ready = in_ready;
  assign rsp_o.valid = out_valid;

endmodule

`default_nettype wire

@@ rtl/ihm_datapath.sv @@
// Datapath: key registers, shared 32x32 hash multiplier, slot memory, probe and result regs.
`default_nettype none

module ihm_datapath import ihm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ihm_cmd_t            cmd_i,
  output ihm_sts_t            sts_o,
  input  logic [KEY_W-1:0]    device_id_i,
  input  logic [KEY_W-1:0]    inode_id_i,
  input  logic [HANDLE_W-1:0] value_handle_i,
  output logic [2:0]          status_o,
  output logic [HANDLE_W-1:0] found_handle_o
);

  // Key and hash registers
  logic [KEY_W-1:0]    dev_q, ino_q, x_q, acc_q, prod_q;
  logic [HANDLE_W-1:0] hnd_q;

  // Probe registers
  logic [IDX_W-1:0]    idx_q, cnt_q, free_q;
  logic                free_vld_q;
  logic [LIVE_W-1:0]   live_q;

  // Result and output registers
  status_e             res_status_q, out_status_q;
  logic [HANDLE_W-1:0] res_handle_q, out_handle_q;

  // Slot memory
  slot_t               mem [CAPACITY];
  slot_t               rd_q;
  slot_t               wr_row;
  logic [IDX_W-1:0]    free_addr, wr_addr;

  logic [HALF_W-1:0]   op_a, op_b;
  logic [KEY_W-1:0]    mul;
  logic [KEY_W-1:0]    prod_hi;
  logic                slot_live;

  // Operand select for the shared multiplier
  always_comb begin
    unique case (cmd_i.hash_step)
      HS_A_LL: begin op_a = x_q[HALF_W-1:0];     op_b = MIX_MUL_A[HALF_W-1:0];     end
      HS_A_LH: begin op_a = x_q[HALF_W-1:0];     op_b = MIX_MUL_A[KEY_W-1:HALF_W]; end
      HS_A_HL: begin op_a = x_q[KEY_W-1:HALF_W]; op_b = MIX_MUL_A[HALF_W-1:0];     end
      HS_B_LL: begin op_a = x_q[HALF_W-1:0];     op_b = MIX_MUL_B[HALF_W-1:0];     end
      HS_B_LH: begin op_a = x_q[HALF_W-1:0];     op_b = MIX_MUL_B[KEY_W-1:HALF_W]; end
      HS_B_HL: begin op_a = x_q[KEY_W-1:HALF_W]; op_b = MIX_MUL_B[HALF_W-1:0];     end
      default: begin op_a = x_q[HALF_W-1:0];     op_b = MIX_MUL_A[HALF_W-1:0];     end
    endcase
  end

  assign mul     = {{HALF_W{1'b0}}, op_a} * {{HALF_W{1'b0}}, op_b};
  assign prod_hi = {prod_q[HALF_W-1:0], {HALF_W{1'b0}}};

  // Key capture and hash sequence
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_key) begin
      dev_q <= device_id_i;
      ino_q <= inode_id_i;
      hnd_q <= value_handle_i;
      x_q   <= device_id_i;
    end else if (cmd_i.hash_en) begin
      prod_q <= mul;
      unique case (cmd_i.hash_step)
        HS_A_LH, HS_B_LH:                     acc_q <= prod_q;
        HS_A_HL, HS_A_ACC, HS_B_HL, HS_B_ACC: acc_q <= acc_q + prod_hi;
        HS_MIX1:                              x_q   <= mix30(ino_q ^ acc_q);
        default: ;
      endcase
    end
  end

  // Slot decode
  assign slot_live = (rd_q.mark == MARK_LIVE);
  assign free_addr = free_vld_q ? free_q : idx_q;
  assign wr_addr   = cmd_i.wr_at_free ? free_addr : idx_q;

  always_comb begin
    wr_row.mark   = cmd_i.wr_mark;
    wr_row.dev    = dev_q;
    wr_row.ino    = ino_q;
    wr_row.handle = hnd_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[idx_q];
    end
  end

  // Probe position, first free slot, live count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      cnt_q      <= '0;
      free_q     <= '0;
      free_vld_q <= 1'b0;
      live_q     <= '0;
    end else begin
      if (cmd_i.hash_en && cmd_i.hash_step == HS_HOME) begin
        idx_q      <= fold27(acc_q);
        cnt_q      <= '0;
        free_vld_q <= 1'b0;
      end else if (cmd_i.advance) begin
        idx_q <= idx_q + 1'b1;
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.track_free && !free_vld_q && !slot_live) begin
        free_q     <= idx_q;
        free_vld_q <= 1'b1;
      end
      if (cmd_i.wr_en && cmd_i.wr_mark == MARK_LIVE) begin
        live_q <= live_q + 1'b1;
      end else if (cmd_i.wr_en && cmd_i.wr_mark == MARK_TOMB && live_q != '0) begin
        live_q <= live_q - 1'b1;
      end
    end
  end

  // Result hold and output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_status;
      res_handle_q <= cmd_i.res_use_handle ? rd_q.handle : '0;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_handle_q <= res_handle_q;
    end
  end

  assign status_o       = out_status_q;
  assign found_handle_o = out_handle_q;

  // Status to controller
  always_comb begin
    sts_o.slot_empty = (rd_q.mark == MARK_EMPTY);
    sts_o.slot_match = slot_live && (rd_q.dev == dev_q) && (rd_q.ino == ino_q);
    sts_o.free_avail = free_vld_q || !slot_live;
    sts_o.probe_last = (cnt_q == '1);
    sts_o.clr_last   = (idx_q == '1);
    sts_o.table_full = (live_q >= LIVE_W'(CAPACITY / 2));
  end

endmodule

`default_nettype wire

@@ rtl/ihm_ctrl.sv @@
// Controller: clearing pass, hash sequencing, probe walk and response handshake.
`default_nettype none

module ihm_ctrl import ihm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic [1:0] mode_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  ihm_sts_t sts_i,
  output ihm_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_HASH  = 6'b000100,
    S_RD    = 6'b001000,
    S_CMP   = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e     state_q, state_d;
  hash_step_e step_q, step_d;
  mode_e      mode_q, mode_d;
  logic       out_vld_q, out_vld_d;

  // Next state and commands
  always_comb begin
    state_d            = state_q;
    step_d             = step_q;
    mode_d             = mode_q;
    in_ready_o         = 1'b0;
    cmd_o              = '0;
    cmd_o.hash_step    = step_q;
    cmd_o.wr_mark      = MARK_EMPTY;
    cmd_o.res_status   = ST_NOT_FOUND;

    unique case (state_q)
      S_CLEAR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.advance = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          mode_d = mode_e'(mode_i);
          if (mode_i == MODE_UNUSED) begin
            cmd_o.res_load = 1'b1;
            state_d        = S_DONE;
          end else begin
            cmd_o.load_key = 1'b1;
            step_d         = HS_A_LL;
            state_d        = S_HASH;
          end
        end
      end
      S_HASH: begin
        cmd_o.hash_en = 1'b1;
        if (step_q == HS_HOME) begin
          state_d = S_RD;
        end else begin
          step_d = hash_step_e'(step_q + 4'd1);
        end
      end
      S_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_CMP;
      end
      S_CMP: begin
        priority if (sts_i.slot_match) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_DONE;
          if (mode_q == MODE_FORGET) begin
            cmd_o.wr_en      = 1'b1;
            cmd_o.wr_mark    = MARK_TOMB;
            cmd_o.res_status = ST_REMOVED;
          end else begin
            cmd_o.res_status     = ST_FOUND;
            cmd_o.res_use_handle = 1'b1;
          end
        end else if (sts_i.slot_empty || sts_i.probe_last) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_DONE;
          if (mode_q == MODE_REMEMBER) begin
            if (!sts_i.table_full && sts_i.free_avail) begin
              cmd_o.wr_en      = 1'b1;
              cmd_o.wr_mark    = MARK_LIVE;
              cmd_o.wr_at_free = 1'b1;
              cmd_o.res_status = ST_INSERTED;
            end else begin
              cmd_o.res_status = ST_FULL;
            end
          end
        end else begin
          cmd_o.track_free = 1'b1;
          cmd_o.advance    = 1'b1;
          state_d          = S_RD;
        end
      end
      S_DONE: begin
        if (!out_vld_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output valid follows the output register
  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_o.out_load) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      step_q    <= HS_A_LL;
      mode_q    <= MODE_LOOKUP;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      mode_q    <= mode_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

`default_nettype wire

@@ rtl/ihm_checker.sv @@
// Port checker for the inode pair hash map, bound to the top level.
`default_nettype none

module ihm_checker import ihm_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [2:0]  rsp_status_i,
  input logic [31:0] rsp_handle_i
);

  // A stalled response holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i)
      && $stable(rsp_handle_i))
    else $error("response changed while stalled");

  // Handle is zero unless found
  a_handle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i != ST_FOUND |-> rsp_handle_i == '0)
    else $error("nonzero handle without found status");

  // Status code in range
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_status_i <= ST_REMOVED)
    else $error("status code out of range");

  // One request in flight: ready drops after an accepted transaction
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while another is in progress");

endmodule

bind inode_pair_hash_map ihm_checker u_ihm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_handle_i (rsp_o.found_handle)
);

`default_nettype wire

@@ tb/tb_inode_pair_hash_map.sv @@
// Self-checking testbench of the inode pair hash map: directed table, random traffic, saturation.
module tb_inode_pair_hash_map;
  import ihm_pkg::*;

  localparam logic [63:0] MUL_A      = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MUL_B      = 64'hBF58_476D_1CE4_E5B9;
  localparam int          RAND_ITEMS = 300;
  localparam int          POOL_N     = 256;
  localparam int          LONG_HOLD  = 600;
  localparam logic [63:0] ONES       = '1;
  localparam logic [63:0] TOP_BIT    = 64'h8000_0000_0000_0000;

  typedef struct packed {
    status_e     status;
    logic [31:0] handle;
  } map_result_t;

  typedef struct packed {
    mode_e       mode;
    logic [63:0] dev;
    logic [63:0] ino;
    logic [31:0] handle;
    bit          fixed;
    status_e     status;
    logic [31:0] found;
  } dir_row_t;

  localparam map_result_t NO_RSP = '{ST_NOT_FOUND, 32'h0};
  localparam int N_DIR = 25;

  // Directed rows on an empty table; fixed rows carry their answer, the rest are predicted
  dir_row_t dir_tbl [N_DIR] = '{
    '{MODE_LOOKUP,   64'h0,   64'h0,   32'h0,         1'b1, ST_NOT_FOUND, 32'h0},
    '{MODE_FORGET,   64'h0,   64'h0,   32'hFFFF_FFFF, 1'b1, ST_NOT_FOUND, 32'h0},
    '{MODE_UNUSED,   64'h0,   64'h0,   32'hFFFF_FFFF, 1'b1, ST_NOT_FOUND, 32'h0},
    '{MODE_REMEMBER, 64'h0,   64'h0,   32'hFFFF_FFFF, 1'b1, ST_INSERTED,  32'h0},
    '{MODE_LOOKUP,   64'h0,   64'h0,   32'h0,         1'b1, ST_FOUND,     32'hFFFF_FFFF},
    '{MODE_REMEMBER, 64'h0,   64'h0,   32'h1234_5678, 1'b1, ST_FOUND,     32'hFFFF_FFFF},
    '{MODE_REMEMBER, ONES,    ONES,    32'h0,         1'b1, ST_INSERTED,  32'h0},
    '{MODE_LOOKUP,   ONES,    ONES,    32'hFFFF_FFFF, 1'b1, ST_FOUND,     32'h0},
    '{MODE_LOOKUP,   ONES,    64'h0,   32'h0,         1'b0, ST_NOT_FOUND, 32'h0},
    '{MODE_REMEMBER, 64'h0,   ONES,    32'hA5A5_A5A5, 1'b1, ST_INSERTED,  32'h0},
    '{MODE_UNUSED,   ONES,    ONES,    32'hFFFF_FFFF, 1'b1, ST_NOT_FOUND, 32'h0},
    '{MODE_LOOKUP,   64'h0,   ONES,    32'h0,         1'b1, ST_FOUND,     32'hA5A5_A5A5},
    '{MODE_FORGET,   64'h0,   64'h0,   32'h0,         1'b1, ST_REMOVED,   32'h0},
    '{MODE_LOOKUP,   64'h0,   64'h0,   32'h0,         1'b1, ST_NOT_FOUND, 32'h0},
    '{MODE_FORGET,   64'h0,   64'h0,   32'h0,         1'b1, ST_NOT_FOUND, 32'h0},
    '{MODE_REMEMBER, 64'h0,   64'h0,   32'h5555_AAAA, 1'b1, ST_INSERTED,  32'h0},
    '{MODE_LOOKUP,   64'h0,   64'h0,   32'h0,         1'b1, ST_FOUND,     32'h5555_AAAA},
    '{MODE_REMEMBER, TOP_BIT, 64'h1,   32'h8000_0001, 1'b0, ST_NOT_FOUND, 32'h0},
    '{MODE_LOOKUP,   TOP_BIT, 64'h1,   32'h0,         1'b0, ST_NOT_FOUND, 32'h0},
    '{MODE_FORGET,   64'h1,   TOP_BIT, 32'h0,         1'b0, ST_NOT_FOUND, 32'h0},
    '{MODE_FORGET,   TOP_BIT, 64'h1,   32'h0,         1'b0, ST_NOT_FOUND, 32'h0},
    '{MODE_FORGET,   ONES,    ONES,    32'h0,         1'b1, ST_REMOVED,   32'h0},
    '{MODE_FORGET,   64'h0,   ONES,    32'h0,         1'b1, ST_REMOVED,   32'h0},
    '{MODE_LOOKUP,   64'h0,   ONES,    32'h0,         1'b1, ST_NOT_FOUND, 32'h0},
    '{MODE_REMEMBER, TOP_BIT, 64'h1,   32'h0,         1'b0, ST_NOT_FOUND, 32'h0}
  };

  logic clk;
  logic rst_n;

  ihm_req_if req_if ();
  ihm_rsp_if rsp_if ();

  inode_pair_hash_map DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Shadow copy of the table
  mark_e       tbl_mark [CAPACITY];
  logic [63:0] tbl_dev  [CAPACITY];
  logic [63:0] tbl_ino  [CAPACITY];
  logic [31:0] tbl_hdl  [CAPACITY];
  int          tbl_live;

  // Key sets: a general pool and one unused key per home slot
  logic [63:0] pool_dev  [POOL_N];
  logic [63:0] pool_ino  [POOL_N];
  logic [63:0] fresh_dev [CAPACITY];
  logic [63:0] fresh_ino [CAPACITY];
  bit          have_fresh [CAPACITY];

  map_result_t pending_rsp_q [$];
  int          mismatch_count;
  int          sent_count;
  bit          src_idle_on;
  bit          quiet;
  bit          long_hold_pending;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Home slot: multiply-xorshift mix masked to the table size
  function automatic int home_of(input logic [63:0] d, input logic [63:0] i);
    logic [63:0] h;
    h = i ^ (d * MUL_A);
    h = h ^ (h >> 30);
    h = h * MUL_B;
    h = h ^ (h >> 27);
    return int'(h[IDX_W-1:0]);
  endfunction

  // Applies one request to the shadow table and returns the response it must produce
  function automatic map_result_t apply_to_map(input mode_e m, input logic [63:0] d,
                                               input logic [63:0] i, input logic [31:0] h);
    map_result_t r;
    int idx;
    int hit;
    int spot;
    r = NO_RSP;
    if (m == MODE_UNUSED) return r;
    idx  = home_of(d, i);
    hit  = -1;
    spot = -1;
    // One walk finds both the key and the first reusable slot
    for (int n = 0; n < CAPACITY; n++) begin
      if (spot < 0 && tbl_mark[idx] != MARK_LIVE) spot = idx;
      if (tbl_mark[idx] == MARK_EMPTY) break;
      if (tbl_mark[idx] == MARK_LIVE && tbl_dev[idx] == d && tbl_ino[idx] == i) begin
        hit = idx;
        break;
      end
      idx = (idx + 1) % CAPACITY;
    end
    if (hit >= 0 && m == MODE_FORGET) begin
      tbl_mark[hit] = MARK_TOMB;
      if (tbl_live > 0) tbl_live--;
      r.status = ST_REMOVED;
    end else if (hit >= 0) begin
      r.status = ST_FOUND;
      r.handle = tbl_hdl[hit];
    end else if (m == MODE_REMEMBER) begin
      if ((tbl_live + 1) * 2 > CAPACITY || spot < 0) begin
        r.status = ST_FULL;
      end else begin
        tbl_mark[spot] = MARK_LIVE;
        tbl_dev[spot]  = d;
        tbl_ino[spot]  = i;
        tbl_hdl[spot]  = h;
        tbl_live++;
        r.status = ST_INSERTED;
      end
    end
    return r;
  endfunction

  // Offers one request, with an occasional idle burst first; called in step with clk, just past its rising edge
  task automatic send_request(input mode_e m, input logic [63:0] d, input logic [63:0] i,
                              input logic [31:0] h, input bit fixed, input map_result_t answer);
    map_result_t r;
    int gap;
    sent_count++;
    if (sent_count % 64 == 0) src_idle_on = ($urandom_range(0, 2) != 0);
    if (!quiet && src_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.mode         <= m;
    req_if.device_id    <= d;
    req_if.inode_id     <= i;
    req_if.value_handle <= h;
    do @(posedge clk); while (!req_if.ready);
    r = apply_to_map(m, d, i, h);
    pending_rsp_q.push_back(fixed ? answer : r);
  endtask

  // Stops offering until every outstanding response has come back
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (pending_rsp_q.size() != 0);
  endtask

  // Response side pacing: random stall bursts, calm stretches, one long hold-off
  initial begin : rsp_pacing
    int stall_left;
    int cyc;
    bit idle_on;
    stall_left = 0;
    cyc        = 0;
    idle_on    = 1'b1;
    rsp_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 256 == 0) idle_on = ($urandom_range(0, 2) != 0);
      if (stall_left > 0) begin
        stall_left--;
      end else if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        stall_left = LONG_HOLD;
      end else if (!quiet && idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 17);
      end
      rsp_if.ready <= (stall_left == 0);
    end
  end

  // Response checker: each transaction against the oldest expectation
  initial begin : rsp_check
    map_result_t want;
    forever begin
      @(posedge clk);
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_rsp_q.size() == 0) begin
          $error("response with none outstanding: status %0d, found_handle %h",
                 rsp_if.status, rsp_if.found_handle);
          mismatch_count++;
        end else begin
          want = pending_rsp_q.pop_front();
          if (rsp_if.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
            mismatch_count++;
          end
          if (rsp_if.found_handle !== want.handle) begin
            $error("found_handle: expected %h, actual %h", want.handle, rsp_if.found_handle);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Watchdog
  initial begin
    #30_000_000;
    $display("** inode_pair_hash_map: FAILED **");
    $finish;
  end

  // Stimulus
  initial begin : stimulus
    logic [63:0] d;
    logic [63:0] i;
    mode_e       m;
    int          s;
    int          k;
    int          b;
    int          pick;
    int          vic;
    int          n_band;
    int          n_cov;

    rst_n               <= 1'b0;
    req_if.valid        <= 1'b0;
    req_if.mode         <= MODE_LOOKUP;
    req_if.device_id    <= '0;
    req_if.inode_id     <= '0;
    req_if.value_handle <= '0;
    mismatch_count    = 0;
    sent_count        = 0;
    src_idle_on       = 1'b1;
    quiet             = 1'b0;
    long_hold_pending = 1'b0;
    tbl_live          = 0;
    for (int n = 0; n < CAPACITY; n++) begin
      tbl_mark[n]   = MARK_EMPTY;
      have_fresh[n] = 1'b0;
    end

    // Key sets: random keys, keys crowded around the wrap point, and near-twins
    for (int n = 0; n < 128; n++) begin
      pool_dev[n] = {$urandom, $urandom};
      pool_ino[n] = {$urandom, $urandom};
    end
    n_band = 0;
    n_cov  = 0;
    while (n_cov < CAPACITY || n_band < 64) begin
      d = {$urandom, $urandom};
      i = {$urandom, $urandom};
      s = home_of(d, i);
      if (n_band < 64 && (s + 8) % CAPACITY < 16) begin
        pool_dev[128 + n_band] = d;
        pool_ino[128 + n_band] = i;
        n_band++;
      end else if (!have_fresh[s]) begin
        have_fresh[s] = 1'b1;
        fresh_dev[s]  = d;
        fresh_ino[s]  = i;
        n_cov++;
      end
    end
    for (int n = 192; n < POOL_N; n++) begin
      b = $urandom_range(0, 127);
      pool_dev[n] = pool_dev[n - 192] ^ ((b < 64) ? (64'h1 << b) : 64'h0);
      pool_ino[n] = pool_ino[n - 192] ^ ((b < 64) ? 64'h0 : (64'h1 << (b - 64)));
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    for (int n = 0; n < N_DIR; n++) begin
      send_request(dir_tbl[n].mode, dir_tbl[n].dev, dir_tbl[n].ino, dir_tbl[n].handle,
                   dir_tbl[n].fixed, map_result_t'{dir_tbl[n].status, dir_tbl[n].found});
    end
    wait_drained();

    // Random traffic, mostly on the key pool
    for (int n = 0; n < RAND_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)      m = MODE_REMEMBER;
      else if (pick < 70) m = MODE_LOOKUP;
      else if (pick < 95) m = MODE_FORGET;
      else                m = MODE_UNUSED;
      if ($urandom_range(0, 99) < 85) begin
        k = $urandom_range(0, POOL_N - 1);
        d = pool_dev[k];
        i = pool_ino[k];
      end else begin
        d = {$urandom, $urandom};
        i = {$urandom, $urandom};
      end
      if (n == 60) long_hold_pending = 1'b1;
      if (n == 150) wait_drained();
      send_request(m, d, i, $urandom, 1'b0, NO_RSP);
    end
    wait_drained();

    // Saturation: fill every empty slot, trading live keys for tombstones once half full
    vic = 0;
    for (s = 0; s < CAPACITY; s++) begin
      if (tbl_mark[s] == MARK_EMPTY) begin
        if ((tbl_live + 1) * 2 > CAPACITY) begin
          while (vic < CAPACITY && !(tbl_mark[vic] == MARK_LIVE &&
                                     home_of(tbl_dev[vic], tbl_ino[vic]) == vic))
            vic++;
          if (vic < CAPACITY)
            send_request(MODE_FORGET, tbl_dev[vic], tbl_ino[vic], $urandom, 1'b0, NO_RSP);
        end
        send_request(MODE_REMEMBER, fresh_dev[s], fresh_ino[s], $urandom, 1'b0, NO_RSP);
      end
    end
    quiet = 1'b1;
    while ((tbl_live + 1) * 2 <= CAPACITY)
      send_request(MODE_REMEMBER, {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
                   1'b0, NO_RSP);

    // No empty slot left: misses walk the whole table
    send_request(MODE_LOOKUP, {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
                 1'b0, NO_RSP);
    send_request(MODE_FORGET, {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
                 1'b0, NO_RSP);
    send_request(MODE_REMEMBER, {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
                 1'b0, NO_RSP);
    send_request(MODE_REMEMBER, pool_dev[128], pool_ino[128], $urandom, 1'b0, NO_RSP);
    vic = 0;
    while (vic < CAPACITY && tbl_mark[vic] != MARK_LIVE) vic++;
    if (vic < CAPACITY)
      send_request(MODE_FORGET, tbl_dev[vic], tbl_ino[vic], $urandom, 1'b0, NO_RSP);
    d = {$urandom, $urandom};
    i = {$urandom, $urandom};
    send_request(MODE_REMEMBER, d, i, $urandom, 1'b0, NO_RSP);
    send_request(MODE_LOOKUP, d, i, $urandom, 1'b0, NO_RSP);

    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0)
      $display("** inode_pair_hash_map: PASSED **");
    else
      $display("** inode_pair_hash_map: FAILED **");
    $finish;
  end

endmodule

@@ files.f @@
rtl/ihm_pkg.sv
rtl/ihm_req_if.sv
rtl/ihm_rsp_if.sv
rtl/ihm_datapath.sv
rtl/ihm_ctrl.sv
rtl/inode_pair_hash_map.sv
rtl/ihm_checker.sv
tb/tb_inode_pair_hash_map.sv
